FILE: sv/vsp_pkg.sv
// Shared types and constants for the visited-set linear probe unit.
// Holds the channel payload structs, action and operation codes, and back-end states.
package vsp_pkg;

  localparam int TABLE_SLOTS_DEF = 65536;
  localparam int KEY_BITS_DEF    = 32;
  localparam int KEY_FIELD_W     = 32;
  localparam int KEY_MAX_W       = 64;
  localparam int ENTRIES_W       = 17;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INSERT = 2'd2,
    OP_CLEAR  = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'd0,
    ST_IDLE  = 2'd1,
    ST_CHECK = 2'd2,
    ST_DONE  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [KEY_FIELD_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic                 stored;
    logic                 full_res;
    logic [ENTRIES_W-1:0] entries;
  } out_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [KEY_MAX_W-1:0] key;
  } cmd_t;

endpackage

FILE: sv/visited_set_linear_probe_unit.sv
// Visited-set linear probe unit: top level joining front end, command queue and back end.
// A lookup or insert probes k slots from its home slot, k from 1 to TABLE_SLOTS; the back end
// finishes one command before it pops the next, while the queue buffers further commands.
// A clear sweeps every slot. After reset the used marks are swept with cmd_stall high;
// entry count and handshakes reset at once.
module visited_set_linear_probe_unit #(
  parameter int TABLE_SLOTS = vsp_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BITS    = vsp_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  vsp_pkg::in_t  cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output vsp_pkg::out_t res
);
  import vsp_pkg::*;

  cmd_t q_in;
  cmd_t q_head;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic sweeping;

  vsp_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_full    (q_full),
    .sweeping  (sweeping),
    .push      (q_push),
    .q_cmd     (q_in)
  );

  vsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  vsp_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .sweeping  (sweeping),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTH
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($countones({res.found, res.stored, res.full_res}) <= 1))
    else $error("more than one outcome flag set in a result beat");

  a_sweep_stall: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> cmd_stall)
    else $error("command beat accepted during the reset sweep");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> sweeping)
    else $error("reset did not start the slot sweep");
`endif

endmodule

FILE: sv/vsp_front.sv
// Front end of the visited-set unit: accepts input beats and classifies them.
// Decodes the action into a command, masks the key, and gates acceptance. Uses vsp_pkg.
module vsp_front #(
  parameter int KEY_BITS = 32
) (
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  vsp_pkg::in_t  cmd,
  input  logic          q_full,
  input  logic          sweeping,
  output logic          push,
  output vsp_pkg::cmd_t q_cmd
);
  import vsp_pkg::*;

  localparam logic [KEY_MAX_W-1:0] KEY_MASK = {KEY_MAX_W{1'b1}} >> (KEY_MAX_W - KEY_BITS);

  assign cmd_stall = q_full || sweeping;
  assign push      = cmd_valid && !cmd_stall;

  always_comb begin
    q_cmd.key = {{(KEY_MAX_W - KEY_FIELD_W){1'b0}}, cmd.key} & KEY_MASK;
    case (cmd.action)
      ACT_LOOKUP: q_cmd.op = OP_LOOKUP;
      ACT_INSERT: q_cmd.op = OP_INSERT;
      ACT_CLEAR:  q_cmd.op = OP_CLEAR;
      default:    q_cmd.op = OP_NOP;
    endcase
  end

endmodule

FILE: sv/vsp_queue.sv
// Short command queue between the front and back ends of the visited-set unit.
// Depth comes from vsp_pkg; each side stalls on its own.
module vsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vsp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output vsp_pkg::cmd_t head
);
  import vsp_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QDEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop)      count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

FILE: sv/vsp_back.sv
// Back end of the visited-set unit: slot memory, probe sequencer and result register.
// Walks one slot per cycle from the home slot; sweeps the used marks on reset and clear.
module vsp_back #(
  parameter int TABLE_SLOTS = 65536,
  parameter int KEY_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  vsp_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          sweeping,
  output logic          res_valid,
  input  logic          res_stall,
  output vsp_pkg::out_t res
);
  import vsp_pkg::*;

  localparam int SB    = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int MW    = KEY_BITS + 1;

  logic [MW-1:0] mem [TABLE_SLOTS];
  logic [MW-1:0] rd_data;

  back_state_t         state;
  back_state_t         state_next;
  cmd_op_t             op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SB-1:0]       home;
  logic [SB-1:0]       pos;
  logic [SB-1:0]       sweep_addr;
  logic [CNT_W-1:0]    count;
  logic                init;
  out_t                result;

  logic                       slot_used;
  logic                       hit;
  logic                       lap;
  logic [SB-1:0]              pos_inc;
  logic [SB-1:0]              cmd_home;
  logic [CNT_W-1:0]           count_inc;
  logic [CNT_W+ENTRIES_W-1:0] now_ext;
  logic [CNT_W+ENTRIES_W-1:0] inc_ext;

  logic          rd_en;
  logic [SB-1:0] rd_addr;
  logic          wr_en;
  logic [SB-1:0] wr_addr;
  logic [MW-1:0] wr_data;
  logic          set_result;
  out_t          result_next;
  logic          load_res;

  assign slot_used = rd_data[KEY_BITS];
  assign hit       = slot_used && (rd_data[KEY_BITS-1:0] == key_r);
  assign pos_inc   = pos + SB'(1);
  assign lap       = pos_inc == home;
  assign cmd_home  = q_cmd.key[SB-1:0];
  assign count_inc = count + CNT_W'(1);
  assign now_ext   = {{ENTRIES_W{1'b0}}, count};
  assign inc_ext   = {{ENTRIES_W{1'b0}}, count_inc};
  assign sweeping  = init;

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (&sweep_addr) state_next = init ? ST_IDLE : ST_DONE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_CLEAR:            state_next = ST_SWEEP;
            OP_LOOKUP, OP_INSERT: state_next = ST_CHECK;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_CHECK: begin
        if (!slot_used || hit || lap) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_SWEEP;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = pos_inc;
    wr_en       = 1'b0;
    wr_addr     = pos;
    wr_data     = {1'b1, key_r};
    set_result  = 1'b0;
    result_next = '0;
    load_res    = 1'b0;
    case (state)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_addr;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_addr = cmd_home;
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = (q_cmd.op == OP_LOOKUP) || (q_cmd.op == OP_INSERT);
          set_result = 1'b1;
          result_next.entries = (q_cmd.op == OP_CLEAR) ? '0 : now_ext[ENTRIES_W-1:0];
        end
      end
      ST_CHECK: begin
        rd_en = slot_used && !hit && !lap;
        wr_en = !slot_used && (op_r == OP_INSERT);
        if (!slot_used || hit || lap) begin
          set_result           = 1'b1;
          result_next.found    = hit;
          result_next.stored   = !slot_used && (op_r == OP_INSERT);
          result_next.full_res = slot_used && !hit && (op_r == OP_INSERT);
          result_next.entries  = (!slot_used && (op_r == OP_INSERT)) ?
                                 inc_ext[ENTRIES_W-1:0] : now_ext[ENTRIES_W-1:0];
        end
      end
      ST_DONE: begin
        load_res = !res_valid || !res_stall;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      init       <= 1'b1;
      sweep_addr <= '0;
      count      <= '0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_addr + SB'(1);
        if (&sweep_addr) init <= 1'b0;
      end
      if (q_pop && (q_cmd.op == OP_CLEAR)) count <= '0;
      if ((state == ST_CHECK) && wr_en)    count <= count_inc;
      if (load_res)       res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r  <= q_cmd.op;
      key_r <= q_cmd.key[KEY_BITS-1:0];
      home  <= cmd_home;
    end
    if (q_pop)                 pos <= cmd_home;
    else if (state == ST_CHECK) pos <= pos_inc;
    if (set_result) result <= result_next;
    if (load_res)   res    <= result;
  end

endmodule

FILE: tb/visited_set_linear_probe_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for visited_set_linear_probe_unit: directed rows, clustered random
// lookups and inserts, then a back-to-back run of homes. Depends on vsp_pkg and the RTL only.
module visited_set_linear_probe_unit_tb;
  import vsp_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int KEY_W = KEY_BITS_DEF;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int RANDOM_ITEMS = 1700;
  localparam int FILL_ITEMS = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_t  cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_t res;

  logic [KEY_W-1:0] shadow_keys [SLOTS];
  bit               shadow_used [SLOTS];
  logic [31:0]      shadow_count = 0;

  out_t             answers_due [$];
  row_t             directed_rows [$];
  logic [KEY_W-1:0] key_pool [$];
  int               mismatches = 0;
  bit               sender_gaps = 1'b1;
  int               burst_left = 0;
  int               stall_mode = 0;
  int               stall_left = 0;
  bit               stall_toggle = 1'b0;

  visited_set_linear_probe_unit #(
    .TABLE_SLOTS(SLOTS),
    .KEY_BITS(KEY_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] expd);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, expd);
    mismatches++;
  endtask

  function automatic bit shadow_holds(input logic [KEY_W-1:0] k);
    logic [SLOT_BITS-1:0] home;
    logic [SLOT_BITS-1:0] pos;
    home = k[SLOT_BITS-1:0];
    pos = home;
    while (shadow_used[pos]) begin
      if (shadow_keys[pos] == k) return 1'b1;
      pos = pos + SLOT_BITS'(1);
      if (pos == home) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic out_t apply_to_shadow_set(input in_t b);
    out_t                 r;
    logic [SLOT_BITS-1:0] pos;
    int unsigned          n;
    bit                   placed;
    r = '0;
    placed = 1'b0;
    case (b.action)
      ACT_CLEAR: begin
        foreach (shadow_used[s]) shadow_used[s] = 1'b0;
        shadow_count = 0;
      end
      ACT_LOOKUP: begin
        r.found = shadow_holds(b.key);
      end
      ACT_INSERT: begin
        if (shadow_holds(b.key)) begin
          r.found = 1'b1;
        end else begin
          pos = b.key[SLOT_BITS-1:0];
          for (n = 0; n < SLOTS && !placed; n++) begin
            if (!shadow_used[pos]) begin
              shadow_used[pos] = 1'b1;
              shadow_keys[pos] = b.key;
              placed = 1'b1;
            end else begin
              pos = pos + SLOT_BITS'(1);
            end
          end
          if (placed) begin
            shadow_count++;
            r.stored = 1'b1;
          end else begin
            r.full_res = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.entries = shadow_count[ENTRIES_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [31:0] k, input bit typed,
                                  input logic f, input logic s, input logic fu, input int ent);
    row_t r;
    r.beat.action = act;
    r.beat.key = k;
    r.typed = typed;
    r.res.found = f;
    r.res.stored = s;
    r.res.full_res = fu;
    r.res.entries = ent[ENTRIES_W-1:0];
    directed_rows.push_back(r);
  endfunction

  task automatic send_beat(input in_t b, input bit typed, input out_t typed_res);
    int   gap;
    out_t predicted;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    cmd_valid <= 1'b1;
    cmd <= b;
    do @(posedge clk); while (cmd_stall);
    predicted = apply_to_shadow_set(b);
    answers_due.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk) begin : drain
    out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (answers_due.size() == 0) begin
        flag_mismatch("result with no pending answer, entries", res.entries, 0);
      end else begin
        want = answers_due.pop_front();
        if (res.found !== want.found) flag_mismatch("found", res.found, want.found);
        if (res.stored !== want.stored) flag_mismatch("stored", res.stored, want.stored);
        if (res.full_res !== want.full_res)
          flag_mismatch("full_res", res.full_res, want.full_res);
        if (res.entries !== want.entries) flag_mismatch("entries", res.entries, want.entries);
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_toggle = ~stall_toggle;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 99) < 25);
      2: res_stall <= ($urandom_range(0, 99) < 60);
      default: res_stall <= stall_toggle;
    endcase
  end

  initial begin : stimulus
    int                   i;
    int                   pick;
    int                   shape;
    int                   clears_left;
    logic [SLOT_BITS-1:0] home;
    logic [SLOT_BITS-1:0] hot_homes [4];
    in_t                  b;
    logic [KEY_W-1:0]     full_key;
    foreach (shadow_used[s]) shadow_used[s] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_row(ACT_LOOKUP, 32'h0000_0000, TYPED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'h0000_0000, TYPED, 0, 1, 0, 1);
    add_row(ACT_INSERT, 32'h0000_0000, TYPED, 1, 0, 0, 1);
    add_row(ACT_LOOKUP, 32'h0000_0000, TYPED, 1, 0, 0, 1);
    add_row(ACT_INSERT, 32'hFFFF_FFFF, TYPED, 0, 1, 0, 2);
    add_row(ACT_INSERT, 32'h0001_0000, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'h0000_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h0000_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h0002_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_UNUSED, 32'hAAAA_5555, TYPED, 0, 0, 0, 4);
    add_row(ACT_UNUSED, 32'h5555_AAAA, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h8000_0000, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'h8000_0000, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'hFFFF_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_CLEAR, 32'h0000_1234, TYPED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'h0000_0000, TYPED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'hFFFF_FFFF, TYPED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'h7FFF_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_INSERT, 32'hFFFF_FFFF, PREDICTED, 0, 0, 0, 0);
    add_row(ACT_LOOKUP, 32'hFFFF_FFFF, PREDICTED, 0, 0, 0, 0);
    foreach (directed_rows[n]) begin
      send_beat(directed_rows[n].beat, directed_rows[n].typed, directed_rows[n].res);
    end

    // cluster homes so probes collide, run long and wrap past the last slot
    hot_homes[0] = SLOT_BITS'(SLOTS - 16);
    hot_homes[1] = '0;
    hot_homes[2] = SLOT_BITS'($urandom());
    hot_homes[3] = SLOT_BITS'($urandom());
    clears_left = 1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      shape = $urandom_range(0, 9);
      b.key = $urandom();
      if (pick < 45) begin
        b.action = ACT_LOOKUP;
      end else if (pick < 94) begin
        b.action = ACT_INSERT;
      end else if (pick < 99 || clears_left == 0 || i < RANDOM_ITEMS / 3) begin
        b.action = ACT_UNUSED;
      end else begin
        b.action = ACT_CLEAR;
        clears_left--;
      end
      if (shape < 4) begin
        home = SLOT_BITS'(hot_homes[$urandom_range(0, 3)] + $urandom_range(0, 47));
        b.key[SLOT_BITS-1:0] = home;
      end else if (shape < 7 && key_pool.size() > 0) begin
        b.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      if (b.action == ACT_INSERT) begin
        key_pool.push_back(b.key);
        if (key_pool.size() > 512) void'(key_pool.pop_front());
      end
      send_beat(b, PREDICTED, '0);
    end

    // fill a run of homes back to back, then probe past its end
    sender_gaps = 1'b0;
    send_beat({ACT_CLEAR, 32'h0}, TYPED, '0);
    for (i = 0; i < FILL_ITEMS; i++) begin
      b.action = ACT_INSERT;
      b.key = $urandom();
      b.key[SLOT_BITS-1:0] = i[SLOT_BITS-1:0];
      send_beat(b, PREDICTED, '0);
    end
    sender_gaps = 1'b1;
    full_key = $urandom();
    full_key[SLOT_BITS-1:0] = SLOT_BITS'($urandom_range(0, FILL_ITEMS - 1));
    if (shadow_keys[full_key[SLOT_BITS-1:0]] == full_key)
      full_key[SLOT_BITS] = ~full_key[SLOT_BITS];
    send_beat({ACT_INSERT, full_key}, PREDICTED, '0);
    send_beat({ACT_LOOKUP, full_key}, PREDICTED, '0);
    send_beat({ACT_INSERT, shadow_keys[full_key[SLOT_BITS-1:0]]}, PREDICTED, '0);
    send_beat({ACT_UNUSED, full_key}, PREDICTED, '0);
    send_beat({ACT_CLEAR, full_key}, TYPED, '0);
    send_beat({ACT_LOOKUP, full_key}, TYPED, '0);

    cmd_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
